@@ design/three_subarray_delay_and_sum_beamformer_defines.svh @@
// ---------------------------------------------------------------------------
// three_subarray_delay_and_sum_beamformer assertion macros
// concurrent checks, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef THREE_SUBARRAY_DELAY_AND_SUM_BEAMFORMER_DEFINES_SVH
`define THREE_SUBARRAY_DELAY_AND_SUM_BEAMFORMER_DEFINES_SVH
`ifndef SYNTHESIS
`define TSBF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TSBF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSBF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TSBF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/tsbf_pkg.sv @@
// ---------------------------------------------------------------------------
// tsbf_pkg
// shared types, constants and small decoders of the beamformer
// ---------------------------------------------------------------------------
`default_nettype none

package tsbf_pkg;

    localparam int NMICS   = 7;
    localparam int NBEAMS  = 3;
    localparam int NREGS   = 6;
    localparam int NREADS  = 9;
    localparam int XW      = 24;
    localparam int GAINW   = 16;
    localparam int PW      = XW + GAINW + 1;
    localparam int GW      = 26;
    localparam int OW      = 9;
    localparam int CFG_IW  = $clog2(NREGS);
    localparam int ACCW    = GW + 2;
    localparam int DIV3_SH = ACCW + 1;
    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);
    localparam int IN_TW   = NMICS * XW;
    localparam int OUT_TW  = ((NBEAMS * GW + 7) / 8) * 8;
    localparam int RND_SH  = 14;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_A_MID = 3'd0;
    localparam logic [CFG_IW-1:0] REG_A_FAR = 3'd1;
    localparam logic [CFG_IW-1:0] REG_B_MID = 3'd2;
    localparam logic [CFG_IW-1:0] REG_B_FAR = 3'd3;
    localparam logic [CFG_IW-1:0] REG_C_MID = 3'd4;
    localparam logic [CFG_IW-1:0] REG_C_FAR = 3'd5;

    // position of a microphone inside its beam
    localparam logic [1:0] POS_FIRST = 2'd0;
    localparam logic [1:0] POS_MID   = 2'd1;
    localparam logic [1:0] POS_FAR   = 2'd2;

    // bias that makes the beam sum non-negative, plus one for rounding
    localparam logic [ACCW-1:0] ACC_BIAS = ACCW'(3 * (2 ** (GW - 1)) + 1);
    localparam logic signed [PW-1:0] RND_HALF = PW'(2 ** (RND_SH - 1));
    // reciprocal of three rounded up, exact floor for any biased sum
    localparam logic [ACCW-1:0] DIV3_MUL = ACCW'((2 ** DIV3_SH + 2) / 3);

    typedef logic [NMICS-1:0][GW-1:0]  t_row;
    typedef logic [NMICS-1:0][XW-1:0]  t_samples;
    typedef logic [NBEAMS-1:0][GW-1:0] t_beams;
    typedef logic [NREGS-1:0][OW-1:0]  t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // c_far -11, c_mid -6, b_far -26, b_mid -13, a_far -78, a_mid -39
    localparam t_cfg CFG_RESET = {9'h1F5, 9'h1FA, 9'h1E6, 9'h1F3, 9'h1B2, 9'h1D9};

    function automatic logic [GAINW-1:0] mic_gain(input logic [2:0] mic);
        logic [GAINW-1:0] g;
        unique case (mic)
            3'd0:    g = 16'd46527;
            3'd1:    g = 16'd20380;
            3'd2:    g = 16'd16384;
            3'd3:    g = 16'd29362;
            3'd4:    g = 16'd40087;
            3'd5:    g = 16'd20768;
            3'd6:    g = 16'd23065;
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic logic [2:0] read_mic(input logic [3:0] k);
        logic [2:0] m;
        unique case (k)
            4'd0:    m = 3'd0;
            4'd1:    m = 3'd3;
            4'd2:    m = 3'd6;
            4'd3:    m = 3'd1;
            4'd4:    m = 3'd3;
            4'd5:    m = 3'd5;
            4'd6:    m = 3'd2;
            4'd7:    m = 3'd3;
            4'd8:    m = 3'd4;
            default: m = 3'd0;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] read_beam(input logic [3:0] k);
        logic [1:0] b;
        unique case (k)
            4'd0, 4'd1, 4'd2: b = 2'd0;
            4'd3, 4'd4, 4'd5: b = 2'd1;
            default:          b = 2'd2;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] read_pos(input logic [3:0] k);
        logic [1:0] p;
        unique case (k)
            4'd0, 4'd3, 4'd6: p = POS_FIRST;
            4'd1, 4'd4, 4'd7: p = POS_MID;
            default:          p = POS_FAR;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ design/tsbf_ram.sv @@
// ---------------------------------------------------------------------------
// tsbf_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module tsbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/tsbf_front.sv @@
// ---------------------------------------------------------------------------
// tsbf_front
// input word register and per-microphone gain with rounding
// ---------------------------------------------------------------------------
`default_nettype none

module tsbf_front import tsbf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_TW-1:0] i_s_tdata,
    input  t_qstat           i_qstat,
    output logic             o_push,
    output t_row             o_row
);

    logic                  r_valid;
    t_samples              r_x;
    logic                  w_accept;
    logic signed [PW-1:0]  w_prod [NMICS];
    logic signed [PW-1:0]  w_rnd  [NMICS];

    assign o_push     = r_valid && !i_qstat.full;
    assign o_s_tready = !r_valid || !i_qstat.full;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= t_samples'(i_s_tdata);
        end
    end

    // round half up, then drop the q14 fraction
    always_comb begin
        for (int m = 0; m < NMICS; m++) begin
            w_prod[m] = $signed(r_x[m]) * $signed({1'b0, mic_gain(3'(m))});
            w_rnd[m]  = w_prod[m] + RND_HALF;
            o_row[m]  = w_rnd[m][RND_SH+GW-1:RND_SH];
        end
    end

endmodule

`default_nettype wire

@@ design/tsbf_queue.sv @@
// ---------------------------------------------------------------------------
// tsbf_queue
// short fifo of gained rows between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module tsbf_queue import tsbf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_row   i_row,
    input  logic   i_pop,
    output t_row   o_row,
    output t_qstat o_qstat
);

    t_row            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QCW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_row;
        end
    end

    assign o_row         = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == QCW'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);

endmodule

`default_nettype wire

@@ design/tsbf_back.sv @@
// ---------------------------------------------------------------------------
// tsbf_back
// history ram, lagged read sequencer, beam sums, divide by three, output word
// ---------------------------------------------------------------------------
`default_nettype none

module tsbf_back import tsbf_pkg::*; #(
    parameter int LOOKAHEAD = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_qstat            i_qstat,
    input  t_row              i_row,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_TW-1:0] o_m_tdata
);

    localparam int HIST_LEN = LOOKAHEAD + 129;
    localparam int AW       = $clog2(HIST_LEN);
    localparam int FW       = $clog2(HIST_LEN + 1);
    localparam int LW       = AW + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [3:0]       r_cnt, n_cnt;
    logic [AW-1:0]    r_wpos;
    logic [AW-1:0]    r_base;
    logic [FW-1:0]    r_fill;
    logic [ACCW-1:0]  r_acc [NBEAMS];
    logic             r_rd_pend;
    logic             r_rd_ok;
    logic [1:0]       r_rd_beam;
    logic [2:0]       r_rd_mic;
    logic             r_out_valid;
    t_beams           r_out;

    logic             w_issue;
    logic             w_div_en;
    logic             w_load_out;
    logic [1:0]       w_beam;
    logic [1:0]       w_pos;
    logic [2:0]       w_mic;
    logic [OW-1:0]    w_off_raw;
    logic signed [OW-1:0] w_off;
    logic signed [LW-1:0] w_lag_s;
    logic [AW-1:0]    w_lag;
    logic [AW:0]      w_sum;
    logic [AW-1:0]    w_raddr;
    logic             w_rd_ok;
    logic [GW-1:0]    w_rd_val;
    t_row             w_rdata;
    logic [2*ACCW-1:0] w_div_prod [NBEAMS];
    logic [ACCW-1:0]  w_div_acc [NBEAMS];

    tsbf_ram #(
        .WIDTH (NMICS * GW),
        .DEPTH (HIST_LEN)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (o_pop),
        .i_waddr (r_wpos),
        .i_wdata (i_row),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_pop      = 1'b0;
        w_issue    = 1'b0;
        w_div_en   = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_READ;
                    n_cnt   = '0;
                end
            end
            ST_READ: begin
                w_issue = 1'b1;
                if (r_cnt == 4'(NREADS - 1)) begin
                    n_state = ST_WAIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_WAIT: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                w_div_en = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // lagged read address and start-up mask
    always_comb begin
        w_beam    = read_beam(r_cnt);
        w_pos     = read_pos(r_cnt);
        w_mic     = read_mic(r_cnt);
        w_off_raw = i_cfg[{w_beam, (w_pos == POS_FAR)}];
        if (w_pos == POS_FIRST) begin
            w_off = '0;
        end else if ($signed(w_off_raw) < -9'sd128) begin
            w_off = -9'sd128;
        end else if ($signed(w_off_raw) > 9'sd128) begin
            w_off = 9'sd128;
        end else begin
            w_off = $signed(w_off_raw);
        end
        w_lag_s = LW'(LOOKAHEAD) - LW'(w_off);
        w_lag   = w_lag_s[LW-1] ? '0 : w_lag_s[AW-1:0];
        w_sum   = {1'b0, r_base} + (AW+1)'(HIST_LEN) - {1'b0, w_lag};
        if (w_sum >= (AW+1)'(HIST_LEN)) begin
            w_raddr = AW'(w_sum - (AW+1)'(HIST_LEN));
        end else begin
            w_raddr = w_sum[AW-1:0];
        end
        w_rd_ok = (FW'(w_lag) < r_fill);
    end

    assign w_rd_val = w_rdata[r_rd_mic];

    // divide by three as a multiply by the rounded-up reciprocal
    always_comb begin
        for (int b = 0; b < NBEAMS; b++) begin
            w_div_prod[b] = r_acc[b] * DIV3_MUL;
            w_div_acc[b]  = ACCW'(w_div_prod[b] >> DIV3_SH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_wpos      <= '0;
            r_fill      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_pend <= w_issue;
            if (o_pop) begin
                r_wpos <= (r_wpos == AW'(HIST_LEN - 1)) ? '0 : r_wpos + 1'b1;
                if (r_fill != FW'(HIST_LEN)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_base <= r_wpos;
        end
        r_rd_ok   <= w_rd_ok;
        r_rd_beam <= w_beam;
        r_rd_mic  <= w_mic;
        if (o_pop) begin
            for (int b = 0; b < NBEAMS; b++) begin
                r_acc[b] <= ACC_BIAS;
            end
        end else if (r_rd_pend && r_rd_ok) begin
            r_acc[r_rd_beam] <= r_acc[r_rd_beam] + ACCW'($signed(w_rd_val));
        end else if (w_div_en) begin
            for (int b = 0; b < NBEAMS; b++) begin
                r_acc[b] <= w_div_acc[b];
            end
        end
        // quotient carries the 2^25 bias, flipping the top bit removes it
        if (w_load_out) begin
            for (int b = 0; b < NBEAMS; b++) begin
                r_out[b] <= {~r_acc[b][GW-1], r_acc[b][GW-2:0]};
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TW - NBEAMS * GW){1'b0}}, r_out};

endmodule

`default_nettype wire

@@ design/three_subarray_delay_and_sum_beamformer.sv @@
// ---------------------------------------------------------------------------
// three_subarray_delay_and_sum_beamformer
// seven-microphone delay-and-sum beamformer with three steered sub-arrays
// ---------------------------------------------------------------------------
// One input word carries one time instant of seven 24-bit samples; every
// word accepted gives exactly one output word with the three beam means.
// The output for sample time t leaves with input word t+LOOKAHEAD, older
// history reads as zero after reset. The front takes a word in any cycle
// while its 4-entry row queue has room. For each word the back does one
// history write, nine lagged reads through the single read port of the
// history ram, a wait for the last read data, one divide-by-three step
// and one output load, which waits until the previous output word is
// taken; it pops no new word before that load. The history ram holds
// LOOKAHEAD+129 rows of seven gained samples and needs no clearing pass:
// a fill counter masks rows not yet written. Offsets must be written
// only while the block is idle; the block itself does not enforce it.
`default_nettype none
`include "three_subarray_delay_and_sum_beamformer_defines.svh"

module three_subarray_delay_and_sum_beamformer import tsbf_pkg::*; #(
    parameter int LOOKAHEAD = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // mic_zero .. mic_six sample, 24 bits each
    input  logic [IN_TW-1:0]  i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // beam_a, beam_b, beam_c, 26 bits each, two zero bits on top
    output logic [OUT_TW-1:0] o_m_tdata,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [OW-1:0]     i_cfg_wdata
);

    t_cfg   r_cfg;
    t_qstat w_qstat;
    logic   w_push;
    logic   w_pop;
    t_row   w_front_row;
    t_row   w_queue_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we && (i_cfg_idx < CFG_IW'(NREGS))) begin
            r_cfg[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    tsbf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_row      (w_front_row)
    );

    tsbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_row   (w_front_row),
        .i_pop   (w_pop),
        .o_row   (w_queue_row),
        .o_qstat (w_qstat)
    );

    tsbf_back #(
        .LOOKAHEAD (LOOKAHEAD)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_qstat    (w_qstat),
        .i_row      (w_queue_row),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    `TSBF_ASSERT_IMP(a_push_room, i_clk, i_rst_n, w_push, !w_qstat.full, "row pushed into full queue")
    `TSBF_ASSERT_IMP(a_pop_data, i_clk, i_rst_n, w_pop, !w_qstat.empty, "row popped from empty queue")
    `TSBF_ASSERT_NXT(a_pop_spacing, i_clk, i_rst_n, w_pop, !w_pop, "back popped two rows in a row")
    `TSBF_ASSERT_IMP(a_ready_room, i_clk, i_rst_n, !o_s_tready, w_qstat.full, "front stalled with queue room")

endmodule

`default_nettype wire

@@ sim/three_subarray_delay_and_sum_beamformer_tb.sv @@
// ---------------------------------------------------------------------------
// three_subarray_delay_and_sum_beamformer_tb
// Feeds seven-microphone sample words through the beamformer under random
// idling on both stream sides and checks every beam word against a local
// model of the gain stage, the delay history and the three steered means.
// Steering offsets are rewritten between phases while the block is idle,
// with in-range, extreme, out-of-range and unused-index writes.
// ---------------------------------------------------------------------------
module three_subarray_delay_and_sum_beamformer_tb import tsbf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOOKAHEAD       = 128;
    localparam int HIST_DEPTH      = LOOKAHEAD + 129;
    localparam int WORDS_PER_PHASE = 100;
    localparam int NPHASES         = 8;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [CFG_IW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IW-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [OW-1:0] OFS_MAX      = 9'h080;
    localparam logic [OW-1:0] OFS_MIN      = 9'h180;
    localparam logic [OW-1:0] OFS_OVER_MAX = 9'h0FF;
    localparam logic [OW-1:0] OFS_OVER_ONE = 9'h081;
    localparam logic [OW-1:0] OFS_UNDER_MAX = 9'h100;
    localparam logic [OW-1:0] OFS_UNDER_ONE = 9'h17F;

    localparam int MIC_GAIN[NMICS] = '{46527, 20380, 16384, 29362, 40087, 20768, 23065};
    localparam int BEAM_MICS[NBEAMS][3] = '{'{0, 3, 6}, '{1, 3, 5}, '{2, 3, 4}};
    localparam logic [CFG_IW-1:0] BEAM_REGS[NBEAMS][2] = '{
        '{REG_A_MID, REG_A_FAR}, '{REG_B_MID, REG_B_FAR}, '{REG_C_MID, REG_C_FAR}
    };
    localparam string BEAM_NAME[NBEAMS] = '{"beam_a", "beam_b", "beam_c"};

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    // mic_zero .. mic_six sample, 24 bits each
    t_samples          i_s_tdata   = '0;
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    // beam_a, beam_b, beam_c, 26 bits each, zero pad on top
    logic [OUT_TW-1:0] o_m_tdata;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx   = '0;
    logic [OW-1:0]     i_cfg_wdata = '0;

    t_samples             sample_q[$];
    t_beams               beam_q[$];
    logic signed [GW-1:0] gained_hist[NMICS][HIST_DEPTH];
    int                   hist_wr;
    t_cfg                 steer_cfg;
    bit                   steady = 1'b0;
    int                   mismatches = 0;
    int                   cycle_cnt = 0;
    t_beams               beam_got;
    t_beams               beam_want;

    three_subarray_delay_and_sum_beamformer #(.LOOKAHEAD(LOOKAHEAD)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic signed [GW-1:0] gain_sample(logic signed [XW-1:0] x, int mic);
        longint p;
        p = longint'(x) * longint'(MIC_GAIN[mic]) + 64'sd8192;
        return GW'(p >>> 14);
    endfunction

    function automatic int steer_offset(logic [CFG_IW-1:0] r);
        int o;
        o = int'($signed(steer_cfg[r]));
        if (o < -128) o = -128;
        if (o > 128) o = 128;
        return o;
    endfunction

    function automatic logic signed [GW-1:0] lagged_sample(int mic, int ofs);
        int lag;
        lag = LOOKAHEAD - ofs;
        if (lag < 0) lag = 0;
        if (lag > HIST_DEPTH - 1) lag = HIST_DEPTH - 1;
        return gained_hist[mic][(hist_wr + HIST_DEPTH - lag) % HIST_DEPTH];
    endfunction

    function automatic void predict_beams(t_samples w);
        t_beams r;
        longint s;
        longint q;
        for (int m = 0; m < NMICS; m++) begin
            gained_hist[m][hist_wr] = gain_sample(w[m], m);
        end
        for (int b = 0; b < NBEAMS; b++) begin
            s = longint'(lagged_sample(BEAM_MICS[b][0], 0))
              + longint'(lagged_sample(BEAM_MICS[b][1], steer_offset(BEAM_REGS[b][0])))
              + longint'(lagged_sample(BEAM_MICS[b][2], steer_offset(BEAM_REGS[b][1])));
            // round to nearest, biased so the division floors
            q = (s + 64'sd1 + (64'sd3 <<< 30)) / 64'sd3 - (64'sd1 <<< 30);
            r[b] = GW'(q);
        end
        beam_q.push_back(r);
        hist_wr = (hist_wr + 1) % HIST_DEPTH;
    endfunction

    function automatic logic [XW-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return XW'($urandom_range(16) - 8);
            default: return XW'($urandom);
        endcase
    endfunction

    function automatic logic [OW-1:0] rand_offset();
        case ($urandom_range(7))
            0:       return OFS_MAX;
            1:       return OFS_MIN;
            2:       return OW'($urandom_range(383, 129));
            3:       return '0;
            default: return OW'($urandom_range(256) - 128);
        endcase
    endfunction

    // input side driver, predicts on every accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_beams(i_s_tdata);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (sample_q.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
                    i_s_tdata  <= sample_q.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= steady || ($urandom_range(99) >= 10);
            if (o_m_tvalid && i_m_tready) begin
                beam_got = t_beams'(o_m_tdata[NBEAMS*GW-1:0]);
                if (beam_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected output word %h", $time, o_m_tdata);
                    end
                end else begin
                    beam_want = beam_q.pop_front();
                    for (int b = 0; b < NBEAMS; b++) begin
                        if (beam_got[b] !== beam_want[b]) begin
                            mismatches++;
                            if (mismatches <= 10) begin
                                $display("%0t: %s expected %0d, got %0d", $time, BEAM_NAME[b],
                                         $signed(beam_want[b]), $signed(beam_got[b]));
                            end
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic wait_idle();
        while (sample_q.size() != 0 || i_s_tvalid || beam_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic load_offsets(t_cfg vals, bit spare);
        for (int r = 0; r < NREGS; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= CFG_IW'(r);
            i_cfg_wdata <= vals[r];
            @(posedge i_clk);
            steer_cfg[r] = vals[r];
        end
        if (spare) begin
            // writes to unused indexes must not land anywhere
            i_cfg_idx   <= REG_SPARE_LO;
            i_cfg_wdata <= rand_offset();
            @(posedge i_clk);
            i_cfg_idx   <= REG_SPARE_HI;
            i_cfg_wdata <= ~vals[0];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_samples w;
        t_cfg vals;
        logic [XW-1:0] fills[8];

        for (int m = 0; m < NMICS; m++) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                gained_hist[m][k] = '0;
            end
        end
        hist_wr = 0;
        steer_cfg[REG_A_MID] = OW'(-39);
        steer_cfg[REG_A_FAR] = OW'(-78);
        steer_cfg[REG_B_MID] = OW'(-13);
        steer_cfg[REG_B_FAR] = OW'(-26);
        steer_cfg[REG_C_MID] = OW'(-6);
        steer_cfg[REG_C_FAR] = OW'(-11);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words: zero, extremes, rounding ties, unit steps, impulses
        fills = '{24'h7FFFFF, 24'h800000, 24'h002000, 24'hFFE000,
                  24'h000800, 24'hFFF800, 24'h000001, 24'hFFFFFF};
        sample_q.push_back('0);
        foreach (fills[i]) begin
            sample_q.push_back({NMICS{fills[i]}});
        end
        for (int m = 0; m < NMICS; m++) begin
            w = '0;
            w[m] = 24'h7FFFFF;
            sample_q.push_back(w);
        end
        sample_q.push_back({NMICS{24'h555555}});
        sample_q.push_back({NMICS{24'hAAAAAA}});

        for (int p = 0; p < NPHASES; p++) begin
            if (p != 0) begin
                wait_idle();
                steady = (p == 3);
                case (p)
                    1:       vals = {NREGS{OFS_MAX}};
                    2:       vals = {NREGS{OFS_MIN}};
                    3:       vals = {OFS_UNDER_MAX, OFS_OVER_MAX, OFS_UNDER_ONE,
                                     OFS_OVER_ONE, OFS_UNDER_MAX, OFS_OVER_MAX};
                    default: begin
                        for (int r = 0; r < NREGS; r++) begin
                            vals[r] = rand_offset();
                        end
                    end
                endcase
                load_offsets(vals, (p == 3) || $urandom_range(1) == 1);
            end
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                for (int m = 0; m < NMICS; m++) begin
                    w[m] = rand_sample();
                end
                sample_q.push_back(w);
            end
        end

        wait_idle();
        repeat (64) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
